[design/tsl_pkg.sv]
// ----------------------------------------------------------------------------
// tsl_pkg
// Shared types and request codes for the timed sleep lock table.
// ----------------------------------------------------------------------------
`default_nettype none

package tsl_pkg;

  // request codes
  localparam logic [1:0] REQ_SUSPEND = 2'd0;
  localparam logic [1:0] REQ_ALLOW   = 2'd1;
  localparam logic [1:0] REQ_QUERY   = 2'd2;

  // control sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SUS,
    ST_QRY
  } state_t;

endpackage

`default_nettype wire

[design/tsl_deadline_mem.sv]
// ----------------------------------------------------------------------------
// tsl_deadline_mem
// Deadline store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tsl_deadline_mem #(
  parameter int DEPTH = 8,
  parameter int W     = 32,
  parameter int AW    = 3
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[design/tsl_later.sv]
// ----------------------------------------------------------------------------
// tsl_later
// Wrap-aware tick compare: a is later than b when a-b is nonzero and positive.
// ----------------------------------------------------------------------------
`default_nettype none

module tsl_later #(
  parameter int W = 32
) (
  input  wire logic [W-1:0] a,
  input  wire logic [W-1:0] b,
  output logic              later
);

  logic [W-1:0] diff;

  assign diff  = a - b;
  assign later = (diff != '0) && !diff[W-1];

endmodule

`default_nettype wire

[design/timed_sleep_lock_table_unit.sv]
// ----------------------------------------------------------------------------
// timed_sleep_lock_table_unit
// Table of sleep locks: active bit per slot plus a deadline in a memory.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                 Word
// request   in         start high, busy low      req_type, slot_id, now_ticks,
//                                                hold_period
// result    out        done pulse, one cycle     sleep_allowed, active_mask
//
// Sequencing per word:
//   allow, bad slot, unused code : busy stays low, result on the next cycle.
//   suspend                      : busy in ST_SUS (deadline read, then
//                                  compare and write back).
//   query                        : busy in ST_QRY; the single read port
//                                  of the deadline memory scans one slot
//                                  per cycle.
// Reset (rst, synchronous) clears the active bits and the sequencer; the
// deadline memory is not cleared, an entry is used only while its bit is set.
// The receiver cannot stall: done is high for exactly one cycle per word, and
// a new request may be accepted in that same cycle.
//
`default_nettype none

module timed_sleep_lock_table_unit #(
  parameter int SLOTS     = 8,
  parameter int TIME_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  req_type,
  input  wire logic [2:0]  slot_id,
  input  wire logic [31:0] now_ticks,
  input  wire logic [30:0] hold_period,
  output logic             done,
  output logic             sleep_allowed,
  output logic [7:0]       active_mask
);

  import tsl_pkg::*;

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int MW = (SLOTS > 8) ? SLOTS : 8;   // padded mask width

  state_t             state, state_next;
  logic [SLOTS-1:0]   active, active_next;
  logic [AW-1:0]      qidx, qidx_next;           // query scan index
  logic [AW-1:0]      slot_r;                    // addressed slot
  logic [TIME_BITS-1:0] until_r;                 // now + period
  logic [TIME_BITS-1:0] now_r;
  logic               done_next, allow_next;

  // deadline memory ports
  logic                 mem_we;
  logic [AW-1:0]        mem_raddr;
  logic [TIME_BITS-1:0] rd_data;

  logic [TIME_BITS-1:0] cmp_a;
  logic                 is_later;
  logic                 slot_ok;
  logic [AW-1:0]        slot_addr;
  logic [TIME_BITS-1:0] now_in;
  logic [MW-1:0]        act_wide;

  assign busy      = (state != ST_IDLE);
  assign slot_ok   = (32'(slot_id) < SLOTS);
  assign slot_addr = AW'(slot_id);
  assign now_in    = TIME_BITS'(now_ticks);

  tsl_deadline_mem #(
    .DEPTH (SLOTS),
    .W     (TIME_BITS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (slot_r),
    .wdata (until_r),
    .raddr (mem_raddr),
    .rdata (rd_data)
  );

  // one comparator shared: suspend checks the new deadline, query checks now
  assign cmp_a = (state == ST_QRY) ? now_r : until_r;

  tsl_later #(
    .W (TIME_BITS)
  ) u_later (
    .a     (cmp_a),
    .b     (rd_data),
    .later (is_later)
  );

  always_comb begin
    state_next  = state;
    active_next = active;
    qidx_next   = qidx;
    done_next   = 1'b0;
    allow_next  = 1'b0;
    mem_we      = 1'b0;
    mem_raddr   = slot_addr;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          case (req_type)
            REQ_SUSPEND: begin
              if (slot_ok) begin
                state_next = ST_SUS;
              end else begin
                done_next = 1'b1;
              end
            end
            REQ_ALLOW: begin
              if (slot_ok) begin
                active_next[slot_addr] = 1'b0;
              end
              done_next = 1'b1;
            end
            REQ_QUERY: begin
              mem_raddr  = '0;
              qidx_next  = '0;
              state_next = ST_QRY;
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end
      ST_SUS: begin
        // take the new deadline unless the held one is later or equal
        if (!active[slot_r] || is_later) begin
          mem_we         = 1'b1;
          active_next[slot_r] = 1'b1;
        end
        done_next  = 1'b1;
        state_next = ST_IDLE;
      end
      ST_QRY: begin
        // expire locks whose deadline is strictly behind now
        if (active[qidx] && is_later) begin
          active_next[qidx] = 1'b0;
        end
        mem_raddr = qidx + AW'(1);
        qidx_next = qidx + AW'(1);
        if (qidx == AW'(SLOTS - 1)) begin
          done_next  = 1'b1;
          allow_next = (active_next == '0);
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign act_wide = MW'(active_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      active <= '0;
      qidx   <= '0;
      done   <= 1'b0;
    end else begin
      state  <= state_next;
      active <= active_next;
      qidx   <= qidx_next;
      done   <= done_next;
    end
  end

  // request word and result word registers
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      slot_r  <= slot_addr;
      now_r   <= now_in;
      until_r <= now_in + TIME_BITS'(hold_period);
    end
    if (done_next) begin
      sleep_allowed <= allow_next;
      active_mask   <= act_wide[7:0];
    end
  end

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while sequencer busy");

  a_allow_empty: assert property (@(posedge clk) disable iff (rst)
    sleep_allowed && done |-> active_mask == 8'd0)
    else $error("sleep allowed with an active lock");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && req_type == REQ_QUERY |=> busy)
    else $error("query did not start a scan");

  a_query_no_set: assert property (@(posedge clk) disable iff (rst)
    state == ST_QRY |=> (active & ~$past(active)) == '0)
    else $error("query scan set a lock");

endmodule

`default_nettype wire
